// ===== hdl/dda_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dda_pkg: shared types and constants of the DDA line rasterizer
// Widths, fixed-point format, command and register codes, and the structs
// passed between the front end, the divider and the back end.
// ============================================================================
package dda_pkg;

	localparam int COORD_BITS   = 13;
	localparam int FRAC_BITS    = 16;
	localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
	localparam int STEP_BITS    = FRAC_BITS + 2;
	localparam int LEN_BITS     = COORD_BITS;
	localparam int REM_BITS     = COORD_BITS + 1;
	localparam int Q_BITS       = FRAC_BITS + 1;
	localparam int CNT_BITS     = $clog2(Q_BITS + 1);
	localparam int CFG_BITS     = 13;
	localparam int INK_BITS     = 8;
	localparam int CFG_IDX_BITS = 2;

	// command queue and result queue depths (powers of two)
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(480);
	localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(640);
	localparam logic [INK_BITS-1:0] INK_VALUE_RST    = INK_BITS'(0);

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_code_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_HEIGHT = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_INK_VALUE    = 2'd2
	} reg_idx_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// one classified command as queued between front and back
	typedef struct packed {
		cmd_code_t           command;
		coord_t              start_col;
		coord_t              start_row;
		coord_t              end_col;
		coord_t              end_row;
		logic [LEN_BITS-1:0] abs_dc;
		logic [LEN_BITS-1:0] abs_dr;
		logic [LEN_BITS-1:0] len;
		logic                dc_neg;
		logic                dr_neg;
		logic                zero_len;
	} cmd_entry_t;

	typedef struct packed {
		logic                start;
		logic [LEN_BITS-1:0] num_col;
		logic [LEN_BITS-1:0] num_row;
		logic [LEN_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [Q_BITS-1:0] q_col;
		logic [Q_BITS-1:0] q_row;
	} div_rsp_t;

	typedef struct packed {
		coord_t col;
		coord_t row;
		logic   last;
	} pix_t;

endpackage

// ===== hdl/dda_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dda_div: two-lane radix-2 increment divider
// Forms |d| * 2^FRAC_BITS / L for both axes, one quotient bit per cycle,
// sharing one bit counter. Requires |d| <= L, so the quotient fits Q_BITS.
// ============================================================================
module dda_div
	import dda_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [LEN_BITS-1:0] den_q;
	logic [REM_BITS-1:0] rem_col_q, rem_row_q;
	logic [Q_BITS-1:0]   q_col_q, q_row_q;

	logic                first;
	logic [REM_BITS-1:0] trial_col, trial_row;
	logic                ge_col, ge_row;

	// first step compares |d| itself (integer quotient bit), later ones shift
	assign first     = (cnt_q == CNT_BITS'(Q_BITS));
	assign trial_col = first ? rem_col_q : {rem_col_q[REM_BITS-2:0], 1'b0};
	assign trial_row = first ? rem_row_q : {rem_row_q[REM_BITS-2:0], 1'b0};
	assign ge_col    = (trial_col >= REM_BITS'(den_q));
	assign ge_row    = (trial_row >= REM_BITS'(den_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_BITS'(Q_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q     <= req.den;
			rem_col_q <= REM_BITS'(req.num_col);
			rem_row_q <= REM_BITS'(req.num_row);
			q_col_q   <= '0;
			q_row_q   <= '0;
		end else if (run_q) begin
			rem_col_q <= ge_col ? trial_col - REM_BITS'(den_q) : trial_col;
			rem_row_q <= ge_row ? trial_row - REM_BITS'(den_q) : trial_row;
			q_col_q   <= {q_col_q[Q_BITS-2:0], ge_col};
			q_row_q   <= {q_row_q[Q_BITS-2:0], ge_row};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.q_col = q_col_q;
	assign rsp.q_row = q_row_q;

endmodule

// ===== hdl/dda_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dda_front: command intake and classification
// Computes deltas, magnitudes and the major-axis length of each beat and
// queues the classified command for the back end.
// ============================================================================
module dda_front
	import dda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       command,
	input  coord_t     start_col,
	input  coord_t     start_row,
	input  coord_t     end_col,
	input  coord_t     end_row,
	output logic       cmd_valid,
	input  logic       cmd_pop,
	output cmd_entry_t cmd_head
);

	cmd_entry_t             cq_q [CQ_DEPTH];
	logic [CQ_AW-1:0]       wr_q, rd_q;
	logic [CQ_AW:0]         cnt_q;

	logic signed [COORD_BITS:0] dc, dr;
	logic [LEN_BITS-1:0]        abs_dc, abs_dr, len;
	cmd_entry_t                 entry;
	logic                       do_push, do_pop;

	always_comb begin
		dc     = (COORD_BITS+1)'(end_col) - (COORD_BITS+1)'(start_col);
		dr     = (COORD_BITS+1)'(end_row) - (COORD_BITS+1)'(start_row);
		abs_dc = dc[COORD_BITS] ? LEN_BITS'(-dc) : LEN_BITS'(dc);
		abs_dr = dr[COORD_BITS] ? LEN_BITS'(-dr) : LEN_BITS'(dr);
		len    = (abs_dc > abs_dr) ? abs_dc : abs_dr;

		entry.command   = cmd_code_t'(command);
		entry.start_col = start_col;
		entry.start_row = start_row;
		entry.end_col   = end_col;
		entry.end_row   = end_row;
		entry.abs_dc    = abs_dc;
		entry.abs_dr    = abs_dr;
		entry.len       = len;
		entry.dc_neg    = dc[COORD_BITS];
		entry.dr_neg    = dr[COORD_BITS];
		entry.zero_len  = (len == '0);
	end

	assign full      = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd_head  = cq_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) cq_q[wr_q] <= entry;
	end

endmodule

// ===== hdl/dda_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dda_back: segment sequencer and pixel stepper
// Runs start and advance commands: loads the accumulators, launches the
// divider, adds one increment per advance and queues the pixels.
// ============================================================================
module dda_back
	import dda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_entry_t cmd_head,
	output logic       cmd_pop,
	output div_req_t   div_req,
	input  div_rsp_t   div_rsp,
	output logic       out_empty,
	input  logic       out_pop,
	output pix_t       out_head
);

	typedef enum logic [1:0] {
		ST_RUN = 2'b01,
		ST_DIV = 2'b10
	} state_t;

	state_t                      state_q;
	logic                        busy_q;
	logic signed [ACC_BITS-1:0]  acc_col_q, acc_row_q;   // biased by one half
	logic signed [STEP_BITS-1:0] step_col_q, step_row_q;
	coord_t                      tgt_col_q, tgt_row_q;
	logic [LEN_BITS-1:0]         steps_left_q;
	logic                        dc_neg_q, dr_neg_q;

	pix_t             oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] oq_wr_q, oq_rd_q;
	logic [OQ_AW:0]   oq_cnt_q;

	logic signed [ACC_BITS-1:0] sum_col, sum_row;
	logic                       emit_v;
	pix_t                       emit_pix;
	logic                       oq_pop;
	logic                       adv_last;

	// truncate toward zero of an already half-biased accumulator
	function automatic coord_t round_pix(input logic signed [ACC_BITS-1:0] b);
		logic adj;
		adj = b[ACC_BITS-1] && (b[FRAC_BITS-1:0] != '0);
		return coord_t'(b[ACC_BITS-1:FRAC_BITS] + COORD_BITS'(adj));
	endfunction

	assign sum_col  = acc_col_q + ACC_BITS'(step_col_q);
	assign sum_row  = acc_row_q + ACC_BITS'(step_row_q);
	assign adv_last = (steps_left_q == LEN_BITS'(1));

	assign cmd_pop = cmd_valid && (state_q == ST_RUN) &&
	                 (oq_cnt_q != (OQ_AW+1)'(OQ_DEPTH));

	always_comb begin
		emit_v   = 1'b0;
		emit_pix = '0;
		if (cmd_pop) begin
			case (cmd_head.command)
				CMD_START: begin
					emit_v        = 1'b1;
					emit_pix.col  = cmd_head.start_col;
					emit_pix.row  = cmd_head.start_row;
					emit_pix.last = cmd_head.zero_len;
				end
				CMD_ADVANCE: begin
					if (busy_q) begin
						emit_v = 1'b1;
						if (adv_last) begin
							emit_pix.col  = tgt_col_q;
							emit_pix.row  = tgt_row_q;
							emit_pix.last = 1'b1;
						end else begin
							emit_pix.col  = round_pix(sum_col);
							emit_pix.row  = round_pix(sum_row);
							emit_pix.last = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		div_req.start   = cmd_pop && (cmd_head.command == CMD_START) && !cmd_head.zero_len;
		div_req.num_col = cmd_head.abs_dc;
		div_req.num_row = cmd_head.abs_dr;
		div_req.den     = cmd_head.len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			busy_q       <= 1'b0;
			acc_col_q    <= '0;
			acc_row_q    <= '0;
			step_col_q   <= '0;
			step_row_q   <= '0;
			tgt_col_q    <= '0;
			tgt_row_q    <= '0;
			steps_left_q <= '0;
			dc_neg_q     <= 1'b0;
			dr_neg_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (cmd_pop && cmd_head.command == CMD_START) begin
						tgt_col_q    <= cmd_head.end_col;
						tgt_row_q    <= cmd_head.end_row;
						acc_col_q    <= $signed({cmd_head.start_col, 1'b1,
						                         (FRAC_BITS-1)'(0)});
						acc_row_q    <= $signed({cmd_head.start_row, 1'b1,
						                         (FRAC_BITS-1)'(0)});
						steps_left_q <= cmd_head.len;
						dc_neg_q     <= cmd_head.dc_neg;
						dr_neg_q     <= cmd_head.dr_neg;
						busy_q       <= !cmd_head.zero_len;
						if (!cmd_head.zero_len) state_q <= ST_DIV;
					end else if (cmd_pop && busy_q) begin
						steps_left_q <= steps_left_q - 1'b1;
						if (adv_last) begin
							busy_q <= 1'b0;
						end else begin
							acc_col_q <= sum_col;
							acc_row_q <= sum_row;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						step_col_q <= dc_neg_q ? -STEP_BITS'(div_rsp.q_col)
						                       : STEP_BITS'(div_rsp.q_col);
						step_row_q <= dr_neg_q ? -STEP_BITS'(div_rsp.q_row)
						                       : STEP_BITS'(div_rsp.q_row);
						state_q    <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// result queue
	assign out_empty = (oq_cnt_q == '0);
	assign oq_pop    = out_pop && !out_empty;
	assign out_head  = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (emit_v) oq_wr_q <= oq_wr_q + 1'b1;
			if (oq_pop) oq_rd_q <= oq_rd_q + 1'b1;
			if (emit_v && !oq_pop)
				oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (oq_pop && !emit_v)
				oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v) oq_q[oq_wr_q] <= emit_pix;
	end

endmodule

// ===== hdl/dda_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dda_line_rasterizer: DDA line rasterizer, top level
// Config registers, in-frame test and the front / divider / back assembly.
// ============================================================================
// Usage:
//  - Command beats are taken on an edge with push high and full low; a start
//    carries both endpoints, an advance asks for the next pixel.
//  - The oldest pixel sits on pixel_col / pixel_row / inside_res /
//    pixel_value / last while empty is low and leaves on an edge with pop high.
//  - A start pixel passes the command queue and the result queue before it
//    shows. A nonzero-length start then runs the divider, one quotient bit
//    per cycle, before the first advance is served. A zero-length segment
//    returns its start pixel marked last and needs no division.
//  - Advances are served one per cycle unless stalled; after L of them the exact
//    endpoint comes out with last set. Advances with no live segment yield nothing.
//  - A 4-deep command queue and a 2-deep result queue let intake and stepping
//    stall on their own while the divider runs or the receiver holds off.
//  - Config writes are registered, no read-back. Reset empties both queues,
//    drops any segment and restores a 640 x 480 frame with ink 0.
// ============================================================================
module dda_line_rasterizer
	import dda_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// command side
	input  logic                    push,
	output logic                    full,
	input  logic                    command,
	input  coord_t                  start_col,
	input  coord_t                  start_row,
	input  coord_t                  end_col,
	input  coord_t                  end_row,
	// pixel side
	output logic                    empty,
	input  logic                    pop,
	output coord_t                  pixel_col,
	output coord_t                  pixel_row,
	output logic                    inside_res,
	output logic [INK_BITS-1:0]     pixel_value,
	output logic                    last,
	// config write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	logic [CFG_BITS-1:0] frame_height_q;
	logic [CFG_BITS-1:0] frame_width_q;
	logic [INK_BITS-1:0] ink_value_q;

	logic       cmd_valid;
	logic       cmd_pop;
	cmd_entry_t cmd_head;
	div_req_t   div_req;
	div_rsp_t   div_rsp;
	pix_t       out_head;

	// config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_height_q <= FRAME_HEIGHT_RST;
			frame_width_q  <= FRAME_WIDTH_RST;
			ink_value_q    <= INK_VALUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_INK_VALUE:    ink_value_q    <= cfg_data[INK_BITS-1:0];
				default: ;
			endcase
		end
	end

	dda_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.start_col (start_col),
		.start_row (start_row),
		.end_col   (end_col),
		.end_row   (end_row),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd_head  (cmd_head)
	);

	dda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_empty (empty),
		.out_pop   (pop),
		.out_head  (out_head)
	);

	assign pixel_col   = out_head.col;
	assign pixel_row   = out_head.row;
	assign last        = out_head.last;
	assign pixel_value = ink_value_q;

	// in frame: both coordinates nonnegative and below the frame size
	assign inside_res = !out_head.row[COORD_BITS-1] && !out_head.col[COORD_BITS-1] &&
	                    (CFG_BITS'($unsigned(out_head.row)) < frame_height_q) &&
	                    (CFG_BITS'($unsigned(out_head.col)) < frame_width_q);

endmodule

// ===== hdl/dda_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dda_checker: port-level checks for the DDA line rasterizer
// Watches the top-level ports only; bound to the top level below.
// ============================================================================
module dda_checker
	import dda_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    empty,
	input logic                    pop,
	input coord_t                  pixel_col,
	input coord_t                  pixel_row,
	input logic                    inside_res,
	input logic [INK_BITS-1:0]     pixel_value,
	input logic                    last,
	input logic                    cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_BITS-1:0]     cfg_data
);

	// a waiting pixel holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pixel_col) &&
		                      $stable(pixel_row) && $stable(last)))
		else $error("waiting pixel changed before pop");

	// ink write shows up on the pixel value in the following cycle
	a_ink: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_INK_VALUE) |=>
		(pixel_value == $past(cfg_data[INK_BITS-1:0])))
		else $error("ink value not applied");

	// an in-frame pixel never has a negative coordinate
	a_inside_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && inside_res) |-> (!pixel_col[COORD_BITS-1] && !pixel_row[COORD_BITS-1]))
		else $error("negative coordinate reported in frame");

	// nothing is waiting right out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty)
		else $error("result present right after reset");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);
